@@ rtl/sfe_pkg.sv @@
// Shared types and constants for the stuffed frame encoder.
// No dependencies; every other rtl file refers to it by scoped names.
package sfe_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned QueueDepthDef = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFlag    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEscape  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFlagSub = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEscSub  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAddress = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCtrl0   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCtrl1   = 3'd6;

  // Reset values
  localparam logic [ByteW-1:0] FlagRst    = 8'h7E;
  localparam logic [ByteW-1:0] EscapeRst  = 8'h7D;
  localparam logic [ByteW-1:0] FlagSubRst = 8'h5E;
  localparam logic [ByteW-1:0] EscSubRst  = 8'h5D;
  localparam logic [ByteW-1:0] AddressRst = 8'h03;
  localparam logic [ByteW-1:0] Ctrl0Rst   = 8'h00;
  localparam logic [ByteW-1:0] Ctrl1Rst   = 8'h40;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             end_of_run;
    logic             end_of_frame;
  } out_word_t;

  typedef struct packed {
    logic [ByteW-1:0] flag_byte;
    logic [ByteW-1:0] escape_byte;
    logic [ByteW-1:0] flag_substitute;
    logic [ByteW-1:0] escape_substitute;
    logic [ByteW-1:0] address_byte;
    logic [ByteW-1:0] control_seq_zero;
    logic [ByteW-1:0] control_seq_one;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] check;  // running check including this byte
    logic             hdr;    // opens a frame
    logic             last;   // closes a frame
    logic             seq;    // sequence bit of the frame
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

@@ rtl/sfe_front.sv @@
// Front end: accepts payload words, tracks frame state, running check and sequence bit.
// Depends on sfe_pkg.
module sfe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  sfe_pkg::in_word_t in_word_i,
  output sfe_pkg::cmd_t     cmd_o
);

  logic                      in_frame_q, in_frame_d;
  logic [sfe_pkg::ByteW-1:0] check_q, check_d;
  logic                      seq_q, seq_d;
  logic [sfe_pkg::ByteW-1:0] new_check;

  always_comb begin
    new_check = (in_frame_q ? check_q : '0) ^ in_word_i.data_byte;

    cmd_o.data  = in_word_i.data_byte;
    cmd_o.check = new_check;
    cmd_o.hdr   = !in_frame_q;
    cmd_o.last  = in_word_i.last_byte;
    cmd_o.seq   = seq_q;

    in_frame_d = in_frame_q;
    check_d    = check_q;
    seq_d      = seq_q;
    if (accept_i) begin
      if (in_word_i.last_byte) begin
        in_frame_d = 1'b0;
        check_d    = '0;
        seq_d      = !seq_q;
      end else begin
        in_frame_d = 1'b1;
        check_d    = new_check;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      check_q    <= '0;
      seq_q      <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      check_q    <= check_d;
      seq_q      <= seq_d;
    end
  end

endmodule

@@ rtl/sfe_queue.sv @@
// Short command queue between front and back.
// Depends on sfe_pkg.
module sfe_queue #(
  parameter int unsigned Depth = sfe_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sfe_pkg::cmd_t       push_cmd_i,
  input  logic                pop_i,
  output sfe_pkg::cmd_t       head_o,
  output sfe_pkg::q_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sfe_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  always_comb begin
    status_o.empty = (cnt_q == '0);
    status_o.full  = (cnt_q == CntW'(Depth));
    do_push = push_i && !status_o.full;
    do_pop  = pop_i && !status_o.empty;
    head_o  = mem_q[rd_ptr_q];

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ rtl/sfe_back.sv @@
// Back end: a queued command gives header (frame opener only), stuffed
// payload byte, stuffed check and closing flag (last byte only), one line
// byte per unstalled cycle into the output register. Depends on sfe_pkg.
module sfe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfe_pkg::cfg_t      cfg_i,
  input  sfe_pkg::cmd_t      head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output sfe_pkg::out_word_t out_word_o,
  input  logic               out_stall_i
);

  localparam logic [3:0] StBegin = 4'd0;
  localparam logic [3:0] StFlag  = 4'd1;
  localparam logic [3:0] StAddr  = 4'd2;
  localparam logic [3:0] StCtrl  = 4'd3;
  localparam logic [3:0] StHcs   = 4'd4;
  localparam logic [3:0] StData  = 4'd5;
  localparam logic [3:0] StDSub  = 4'd6;
  localparam logic [3:0] StChk   = 4'd7;
  localparam logic [3:0] StCSub  = 4'd8;
  localparam logic [3:0] StClose = 4'd9;

  logic [3:0]                st_q, st_d, cur, nxt;
  logic                      adv, load, done, eof;
  logic [sfe_pkg::ByteW-1:0] byte_v, ctrl;
  logic                      d_flag, d_esc, c_flag, c_esc;
  logic                      out_valid_q;
  sfe_pkg::out_word_t        out_word_q;

  always_comb begin
    adv  = !out_valid_q || !out_stall_i;
    load = adv && head_valid_i;

    ctrl   = head_i.seq ? cfg_i.control_seq_one : cfg_i.control_seq_zero;
    d_flag = (head_i.data == cfg_i.flag_byte);
    d_esc  = (head_i.data == cfg_i.escape_byte);
    c_flag = (head_i.check == cfg_i.flag_byte);
    c_esc  = (head_i.check == cfg_i.escape_byte);

    cur = (st_q == StBegin) ? (head_i.hdr ? StFlag : StData) : st_q;

    byte_v = cfg_i.flag_byte;
    nxt    = StBegin;
    done   = 1'b0;
    eof    = 1'b0;
    unique case (cur)
      StFlag: begin
        byte_v = cfg_i.flag_byte;
        nxt    = StAddr;
      end
      StAddr: begin
        byte_v = cfg_i.address_byte;
        nxt    = StCtrl;
      end
      StCtrl: begin
        byte_v = ctrl;
        nxt    = StHcs;
      end
      StHcs: begin
        byte_v = cfg_i.address_byte ^ ctrl;
        nxt    = StData;
      end
      StData: begin
        if (d_flag || d_esc) begin
          byte_v = cfg_i.escape_byte;
          nxt    = StDSub;
        end else begin
          byte_v = head_i.data;
          nxt    = StChk;
          done   = !head_i.last;
        end
      end
      StDSub: begin
        byte_v = d_flag ? cfg_i.flag_substitute : cfg_i.escape_substitute;
        nxt    = StChk;
        done   = !head_i.last;
      end
      StChk: begin
        if (c_flag || c_esc) begin
          byte_v = cfg_i.escape_byte;
          nxt    = StCSub;
        end else begin
          byte_v = head_i.check;
          nxt    = StClose;
        end
      end
      StCSub: begin
        byte_v = c_flag ? cfg_i.flag_substitute : cfg_i.escape_substitute;
        nxt    = StClose;
      end
      StClose: begin
        byte_v = cfg_i.flag_byte;
        eof    = 1'b1;
        done   = 1'b1;
      end
      default: begin
        byte_v = cfg_i.flag_byte;
        done   = 1'b1;
      end
    endcase

    pop_o = load && done;
    st_d  = st_q;
    if (load) begin
      st_d = done ? StBegin : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StBegin;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (adv) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q.out_byte     <= byte_v;
      out_word_q.end_of_run   <= done;
      out_word_q.end_of_frame <= eof;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ rtl/stuffed_frame_encoder.sv @@
// Top level of the stuffed frame encoder: configuration registers, front end,
// command queue and back end. Depends on sfe_pkg, sfe_front, sfe_queue, sfe_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one payload
//   byte per word, with last_byte marking the end of a frame. Output channel
//   (out_valid_o / out_stall_i / out_word_o) gives one line byte per word.
//   A frame-opening byte yields flag, address, control and header check ahead
//   of the payload; flag and escape bytes in payload and check are escaped.
//   The last byte adds the stuffed check and the closing flag.
//   A word passes through the command queue and the output register before
//   its first line byte is valid. The back end emits one line byte per cycle
//   unless the output is stalled, and pops a word with its last line byte.
//   The front end takes a new word every cycle while the command queue
//   (QueueDepth entries) has room; in_stall_o is high only when it is full.
//   Receiver stall: the output register holds its word; the back end freezes,
//   the queue fills and then the input stalls.
//   Config port (cfg_valid_i / cfg_ready_o) is always ready; writes to an
//   unused index are dropped. Write only while the block is idle.
//   Reset: all registers take their defaults, no frame is open, sequence
//   bit zero, queue and output register empty.
module stuffed_frame_encoder #(
  parameter int unsigned QueueDepth = sfe_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sfe_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sfe_pkg::out_word_t           out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfe_pkg::ByteW-1:0]    cfg_data_i
);

  sfe_pkg::cfg_t      cfg_q;
  sfe_pkg::cmd_t      push_cmd, head_cmd;
  sfe_pkg::q_status_t q_status;
  logic               in_accept, pop;

  // Config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte         <= sfe_pkg::FlagRst;
      cfg_q.escape_byte       <= sfe_pkg::EscapeRst;
      cfg_q.flag_substitute   <= sfe_pkg::FlagSubRst;
      cfg_q.escape_substitute <= sfe_pkg::EscSubRst;
      cfg_q.address_byte      <= sfe_pkg::AddressRst;
      cfg_q.control_seq_zero  <= sfe_pkg::Ctrl0Rst;
      cfg_q.control_seq_one   <= sfe_pkg::Ctrl1Rst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sfe_pkg::CfgFlag:    cfg_q.flag_byte         <= cfg_data_i;
        sfe_pkg::CfgEscape:  cfg_q.escape_byte       <= cfg_data_i;
        sfe_pkg::CfgFlagSub: cfg_q.flag_substitute   <= cfg_data_i;
        sfe_pkg::CfgEscSub:  cfg_q.escape_substitute <= cfg_data_i;
        sfe_pkg::CfgAddress: cfg_q.address_byte      <= cfg_data_i;
        sfe_pkg::CfgCtrl0:   cfg_q.control_seq_zero  <= cfg_data_i;
        sfe_pkg::CfgCtrl1:   cfg_q.control_seq_one   <= cfg_data_i;
        default: ;  // unused index, dropped
      endcase
    end
  end

  // Front accepts whenever the queue has room
  assign in_stall_o = q_status.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  sfe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_word_i (in_word_i),
    .cmd_o     (push_cmd)
  );

  sfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .status_o   (q_status)
  );

  sfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head_cmd),
    .head_valid_i (!q_status.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o),
    .out_stall_i  (out_stall_i)
  );

  // Checks
  a_eof_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.end_of_frame |-> out_word_o.end_of_run)
    else $error("closing flag not marked as end of run");

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_pop_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && out_word_o.end_of_run)
    else $error("completed command did not end a run");

endmodule
